FILE: hdl/tcmc_pkg.sv
`timescale 1ns / 1ps
package tcmc_pkg;

   localparam int ROUNDS      = 16;
   localparam int MAX_MSG_LEN = 65535;
   localparam int RND_W       = $clog2(ROUNDS + 1);

   localparam logic [31:0] DELTA    = 32'h9E3779B9;
   localparam logic [31:0] SUM_INIT = 32'(64'(DELTA) * 64'(ROUNDS));

   localparam int CSR_AW = 3;
   localparam logic [CSR_AW-1:0] CSR_KEY0 = 3'd0;
   localparam logic [CSR_AW-1:0] CSR_KEY1 = 3'd1;
   localparam logic [CSR_AW-1:0] CSR_KEY2 = 3'd2;
   localparam logic [CSR_AW-1:0] CSR_KEY3 = 3'd3;
   localparam logic [CSR_AW-1:0] CSR_CAP  = 3'd4;
   localparam logic [CSR_AW-1:0] CSR_FILL = 3'd5;

   localparam logic [15:0] CAP_RESET  = 16'hFFFF;
   localparam logic [7:0]  FILL_RESET = 8'hAD;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_LEN  = 2'd1;
   localparam logic [1:0] ST_OVER_CAP = 2'd2;
   localparam logic [1:0] ST_BAD_PAD  = 2'd3;

   localparam logic [1:0] KIND_ENC  = 2'd0;
   localparam logic [1:0] KIND_DEC  = 2'd1;
   localparam logic [1:0] KIND_STAT = 2'd2;

   typedef struct packed {
      logic        req_type;
      logic [7:0]  in_byte;
      logic        first;
      logic [15:0] msg_len;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_data;
      logic [1:0] status;
      logic       end_of_run;
      logic       end_of_message;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        newmsg;
      logic        eor;
      logic        eom;
      logic [1:0]  status;
      logic [15:0] rem;
      logic [63:0] blk;
   } job_type;

endpackage

FILE: hdl/tcmc_front.sv
`timescale 1ns / 1ps
module tcmc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tcmc_pkg::req_payload_type req_payload,
   input  logic [7:0]                fill_byte,
   output logic                      push_valid,
   input  logic                      push_ready,
   output tcmc_pkg::job_type         push_job
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_ENC  = 2'd1;
   localparam logic [1:0] PH_DEC  = 2'd2;

   logic [1:0]        phase_ff, phase_in;
   logic [63:0]       buf_ff, buf_in;
   logic [2:0]        pos_ff, pos_in;
   logic [15:0]       rem_ff, rem_in;
   logic              newmsg_ff, newmsg_in;
   logic              hold_valid_ff, hold_valid_in;
   tcmc_pkg::job_type hold_job_ff, hold_job_in;

   tcmc_pkg::job_type job0, job1;
   logic              job0_v, job1_v;
   logic              accept;
   logic [15:0]       len, rem_after;
   logic [2:0]        pad;
   logic [3:0]        pad2, pad3, n;
   logic [7:0]        hdr, d;
   logic [127:0]      s;
   logic [63:0]       nb;
   logic              bad;

   assign req_stall = !push_ready || hold_valid_ff;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      phase_in      = phase_ff;
      buf_in        = buf_ff;
      pos_in        = pos_ff;
      rem_in        = rem_ff;
      newmsg_in     = newmsg_ff;
      hold_valid_in = hold_valid_ff;
      hold_job_in   = hold_job_ff;
      job0          = '0;
      job1          = '0;
      job0_v        = 1'b0;
      job1_v        = 1'b0;
      d             = req_payload.in_byte;
      len           = req_payload.msg_len;
      pad           = 3'd6 - len[2:0];
      pad2          = {1'b0, pad} + 4'd2;
      pad3          = {1'b0, pad} + 4'd3;
      n             = {1'b0, pad} + 4'd4;
      hdr           = (fill_byte & 8'hF8) | {5'b0, pad};
      bad           = (len == 16'd0) || ({16'b0, len} > 32'(tcmc_pkg::MAX_MSG_LEN)) ||
                      (req_payload.req_type && ((len[2:0] != 3'd0) || (len < 16'd16)));
      rem_after     = rem_ff - 16'd1;
      nb            = buf_ff;
      nb[{3'd7 - pos_ff, 3'b000} +: 8] = d;
      for (int k = 0; k < 16; k++) begin
         if (k == 0)
            s[8*(15-k) +: 8] = hdr;
         else if (4'(k) <= pad2)
            s[8*(15-k) +: 8] = fill_byte;
         else if (4'(k) == pad3)
            s[8*(15-k) +: 8] = d;
         else
            s[8*(15-k) +: 8] = 8'h00;
      end

      if (hold_valid_ff && push_ready)
         hold_valid_in = 1'b0;

      if (accept) begin
         if (req_payload.first) begin
            pos_in    = 3'd0;
            buf_in    = '0;
            newmsg_in = 1'b1;
            rem_in    = len - 16'd1;
            if (bad) begin
               job0.kind   = tcmc_pkg::KIND_STAT;
               job0.newmsg = 1'b1;
               job0.eor    = 1'b1;
               job0.eom    = 1'b1;
               job0.status = tcmc_pkg::ST_BAD_LEN;
               job0_v      = 1'b1;
               phase_in    = PH_IDLE;
            end else if (!req_payload.req_type) begin
               job0.kind   = tcmc_pkg::KIND_ENC;
               job0.newmsg = 1'b1;
               job0.blk    = s[127:64];
               if (len == 16'd1) begin
                  // header, data and trailer fill two whole blocks
                  job0_v      = 1'b1;
                  job1.kind   = tcmc_pkg::KIND_ENC;
                  job1.blk    = s[63:0];
                  job1.eor    = 1'b1;
                  job1.eom    = 1'b1;
                  job1_v      = 1'b1;
                  newmsg_in   = 1'b0;
                  phase_in    = PH_IDLE;
               end else if (n >= 4'd8) begin
                  job0.eor  = 1'b1;
                  job0_v    = 1'b1;
                  buf_in    = s[63:0];
                  pos_in    = 3'(n - 4'd8);
                  newmsg_in = 1'b0;
                  phase_in  = PH_ENC;
               end else begin
                  buf_in   = s[127:64];
                  pos_in   = n[2:0];
                  phase_in = PH_ENC;
               end
            end else begin
               buf_in   = {d, 56'b0};
               pos_in   = 3'd1;
               phase_in = PH_DEC;
            end
         end else begin
            unique case (phase_ff)
               PH_ENC: begin
                  rem_in = rem_after;
                  if ((rem_after == 16'd0) || (pos_ff == 3'd7)) begin
                     job0.kind   = tcmc_pkg::KIND_ENC;
                     job0.newmsg = newmsg_ff;
                     job0.blk    = nb;
                     job0.eor    = 1'b1;
                     job0.eom    = (rem_after == 16'd0);
                     job0_v      = 1'b1;
                     buf_in      = '0;
                     pos_in      = 3'd0;
                     newmsg_in   = 1'b0;
                     if (rem_after == 16'd0)
                        phase_in = PH_IDLE;
                  end else begin
                     buf_in = nb;
                     pos_in = pos_ff + 3'd1;
                  end
               end
               PH_DEC: begin
                  rem_in = rem_after;
                  if (pos_ff == 3'd7) begin
                     job0.kind   = tcmc_pkg::KIND_DEC;
                     job0.newmsg = newmsg_ff;
                     job0.blk    = nb;
                     job0.rem    = rem_after;
                     job0.eor    = 1'b1;
                     job0_v      = 1'b1;
                     buf_in      = '0;
                     pos_in      = 3'd0;
                     newmsg_in   = 1'b0;
                     if (rem_after == 16'd0)
                        phase_in = PH_IDLE;
                  end else begin
                     buf_in = nb;
                     pos_in = pos_ff + 3'd1;
                  end
               end
               default: begin
               end
            endcase
         end
      end

      if (job1_v) begin
         hold_valid_in = 1'b1;
         hold_job_in   = job1;
      end
   end

   assign push_valid = hold_valid_ff || job0_v;
   assign push_job   = hold_valid_ff ? hold_job_ff : job0;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         buf_ff        <= '0;
         pos_ff        <= 3'd0;
         rem_ff        <= 16'd0;
         newmsg_ff     <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         buf_ff        <= buf_in;
         pos_ff        <= pos_in;
         rem_ff        <= rem_in;
         newmsg_ff     <= newmsg_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_job_ff <= hold_job_in;
   end

endmodule

FILE: hdl/tcmc_fifo.sv
`timescale 1ns / 1ps
module tcmc_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  tcmc_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop,
   output tcmc_pkg::job_type pop_job
);

   tcmc_pkg::job_type mem_ff [4];
   logic [1:0]        wr_ff, rd_ff;
   logic [2:0]        cnt_ff;
   logic              do_push, do_pop;

   assign push_ready = (cnt_ff != 3'd4);
   assign pop_valid  = (cnt_ff != 3'd0);
   assign pop_job    = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 2'd0;
         rd_ff  <= 2'd0;
         cnt_ff <= 3'd0;
      end else begin
         if (do_push)
            wr_ff <= wr_ff + 2'd1;
         if (do_pop)
            rd_ff <= rd_ff + 2'd1;
         if (do_push && !do_pop)
            cnt_ff <= cnt_ff + 3'd1;
         else if (do_pop && !do_push)
            cnt_ff <= cnt_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push)
         mem_ff[wr_ff] <= push_job;
   end

endmodule

FILE: hdl/tcmc_engine.sv
`timescale 1ns / 1ps
module tcmc_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_pop,
   input  tcmc_pkg::job_type job_in,
   input  logic [31:0]       key0,
   input  logic [31:0]       key1,
   input  logic [31:0]       key2,
   input  logic [31:0]       key3,
   output logic              slot_valid,
   output tcmc_pkg::job_type slot,
   input  logic              slot_take
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]                  st_ff, st_in;
   logic [tcmc_pkg::RND_W-1:0]  cnt_ff, cnt_in;
   logic [31:0]                 y_ff, y_in, z_ff, z_in, sum_ff, sum_in;
   logic [63:0]                 aux_ff, aux_in, pc_ff, pc_in, pm_ff, pm_in;
   tcmc_pkg::job_type           job_ff, job_in_r;
   tcmc_pkg::job_type           slot_ff, slot_in;
   logic                        slot_valid_ff, slot_valid_in;
   logic [63:0]                 pc0, pm0, v, c, mid;
   logic [31:0]                 ny, nz;

   function automatic logic [31:0] mix(input logic [31:0] w, input logic [31:0] ka,
                                       input logic [31:0] kb, input logic [31:0] sm);
      return ((w << 4) + ka) ^ (w + sm) ^ ((w >> 5) + kb);
   endfunction

   always_comb begin
      st_in         = st_ff;
      cnt_in        = cnt_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      sum_in        = sum_ff;
      aux_in        = aux_ff;
      pc_in         = pc_ff;
      pm_in         = pm_ff;
      job_in_r      = job_ff;
      slot_in       = slot_ff;
      slot_valid_in = slot_valid_ff && !slot_take;
      job_pop       = 1'b0;
      pc0           = job_in.newmsg ? 64'd0 : pc_ff;
      pm0           = job_in.newmsg ? 64'd0 : pm_ff;
      v             = (job_in.kind == tcmc_pkg::KIND_ENC) ? (job_in.blk ^ pc0)
                                                          : (job_in.blk ^ pm0);
      ny            = '0;
      nz            = '0;
      c             = {y_ff, z_ff} ^ pm_ff;
      mid           = {y_ff, z_ff};

      unique case (st_ff)
         S_IDLE: begin
            if (job_valid) begin
               job_pop  = 1'b1;
               job_in_r = job_in;
               cnt_in   = '0;
               if (job_in.kind == tcmc_pkg::KIND_STAT) begin
                  st_in = S_DONE;
               end else begin
                  pc_in  = pc0;
                  pm_in  = pm0;
                  y_in   = v[63:32];
                  z_in   = v[31:0];
                  if (job_in.kind == tcmc_pkg::KIND_ENC) begin
                     aux_in = v;
                     sum_in = tcmc_pkg::DELTA;
                  end else begin
                     aux_in = job_in.blk;
                     sum_in = tcmc_pkg::SUM_INIT;
                  end
                  st_in = S_RUN;
               end
            end
         end
         S_RUN: begin
            if (job_ff.kind == tcmc_pkg::KIND_ENC) begin
               ny     = y_ff + mix(z_ff, key0, key1, sum_ff);
               nz     = z_ff + mix(ny, key2, key3, sum_ff);
               sum_in = sum_ff + tcmc_pkg::DELTA;
            end else begin
               nz     = z_ff - mix(y_ff, key2, key3, sum_ff);
               ny     = y_ff - mix(nz, key0, key1, sum_ff);
               sum_in = sum_ff - tcmc_pkg::DELTA;
            end
            y_in   = ny;
            z_in   = nz;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == tcmc_pkg::RND_W'(tcmc_pkg::ROUNDS - 1))
               st_in = S_DONE;
         end
         S_DONE: begin
            // wait for the hand-off register to empty
            if (!slot_valid_ff) begin
               slot_valid_in = 1'b1;
               slot_in       = job_ff;
               if (job_ff.kind == tcmc_pkg::KIND_ENC) begin
                  slot_in.blk = c;
                  pm_in       = aux_ff;
                  pc_in       = c;
               end else if (job_ff.kind == tcmc_pkg::KIND_DEC) begin
                  slot_in.blk = mid ^ pc_ff;
                  pm_in       = mid;
                  pc_in       = aux_ff;
               end
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   assign slot_valid = slot_valid_ff;
   assign slot       = slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff         <= S_IDLE;
         cnt_ff        <= '0;
         slot_valid_ff <= 1'b0;
         pc_ff         <= '0;
         pm_ff         <= '0;
      end else begin
         st_ff         <= st_in;
         cnt_ff        <= cnt_in;
         slot_valid_ff <= slot_valid_in;
         pc_ff         <= pc_in;
         pm_ff         <= pm_in;
      end
   end

   always_ff @(posedge clock) begin
      y_ff    <= y_in;
      z_ff    <= z_in;
      sum_ff  <= sum_in;
      aux_ff  <= aux_in;
      job_ff  <= job_in_r;
      slot_ff <= slot_in;
   end

endmodule

FILE: hdl/tcmc_emitter.sv
`timescale 1ns / 1ps
module tcmc_emitter (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      slot_valid,
   input  tcmc_pkg::job_type         slot,
   output logic                      slot_take,
   input  logic [15:0]               out_capacity,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tcmc_pkg::rsp_payload_type rsp_payload
);

   logic                      active_ff, active_in;
   logic [3:0]                j_ff, j_in;
   logic [8:0]                mask_ff, mask_in;
   logic [63:0]               blk_ff, blk_in;
   logic [1:0]                stat_ff, stat_in;
   logic                      eor_ff, eor_in, eom_ff, eom_in;
   logic [3:0]                skip_ff, skip_in;
   logic                      drop_ff, drop_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   tcmc_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic [17:0] count;
   logic [3:0]  skip0;
   logic        bad, cur, out_free, last;
   logic [8:0]  higher;
   logic [7:0]  b;

   assign slot_take = slot_valid && !active_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      active_in    = active_ff;
      j_in         = j_ff;
      mask_in      = mask_ff;
      blk_in       = blk_ff;
      stat_in      = stat_ff;
      eor_in       = eor_ff;
      eom_in       = eom_ff;
      skip_in      = skip_ff;
      drop_in      = drop_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      count        = {2'b0, slot.rem} + 18'd8 - {15'b0, slot.blk[58:56]} - 18'd10;
      skip0        = slot.newmsg ? ({1'b0, slot.blk[58:56]} + 4'd3) : skip_ff;
      bad          = 1'b0;
      b            = '0;
      higher       = mask_ff >> j_ff;
      last         = !(|higher[8:1]);
      cur          = mask_ff[j_ff];

      if (slot_take) begin
         if (slot.newmsg)
            drop_in = 1'b0;
         if (!(drop_ff && !slot.newmsg)) begin
            active_in = 1'b1;
            j_in      = 4'd0;
            blk_in    = slot.blk;
            unique case (slot.kind)
               tcmc_pkg::KIND_ENC: begin
                  mask_in = 9'h0FF;
                  stat_in = tcmc_pkg::ST_OK;
                  eor_in  = slot.eor;
                  eom_in  = slot.eom;
               end
               tcmc_pkg::KIND_STAT: begin
                  mask_in = 9'h100;
                  stat_in = slot.status;
                  eor_in  = 1'b1;
                  eom_in  = 1'b1;
               end
               tcmc_pkg::KIND_DEC: begin
                  eor_in = 1'b1;
                  if (slot.newmsg && count[17]) begin
                     mask_in = 9'h100;
                     stat_in = tcmc_pkg::ST_BAD_LEN;
                     eom_in  = 1'b1;
                     drop_in = 1'b1;
                  end else if (slot.newmsg && (count[16:0] > {1'b0, out_capacity})) begin
                     mask_in = 9'h100;
                     stat_in = tcmc_pkg::ST_OVER_CAP;
                     eom_in  = 1'b1;
                     drop_in = 1'b1;
                  end else begin
                     // drop header bytes, pass data, check the zero trailer
                     for (int j = 0; j < 8; j++) begin
                        mask_in[j] = (4'(j) >= skip0) && (slot.rem >= 16'(j));
                        bad = bad | ((4'(j) >= skip0) && (slot.rem < 16'(j)) &&
                                     (slot.blk[8*(7-j) +: 8] != 8'h00));
                     end
                     mask_in[8] = (slot.rem == 16'd0);
                     stat_in    = bad ? tcmc_pkg::ST_BAD_PAD : tcmc_pkg::ST_OK;
                     eom_in     = (slot.rem == 16'd0);
                     skip_in    = (skip0 > 4'd8) ? (skip0 - 4'd8) : 4'd0;
                  end
               end
               default: active_in = 1'b0;
            endcase
         end
      end else if (active_ff && (!cur || out_free)) begin
         if (cur) begin
            if (j_ff != 4'd8)
               b = blk_ff[{3'd7 - j_ff[2:0], 3'b000} +: 8];
            rsp_valid_in          = 1'b1;
            rsp_in.out_byte       = b;
            rsp_in.has_data       = (j_ff != 4'd8);
            rsp_in.status         = (j_ff == 4'd8) ? stat_ff : tcmc_pkg::ST_OK;
            rsp_in.end_of_run     = last && eor_ff;
            rsp_in.end_of_message = last && eom_ff;
         end
         if (j_ff == 4'd8)
            active_in = 1'b0;
         else
            j_in = j_ff + 4'd1;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         j_ff         <= 4'd0;
         skip_ff      <= 4'd0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         j_ff         <= j_in;
         skip_ff      <= skip_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff <= mask_in;
      blk_ff  <= blk_in;
      stat_ff <= stat_in;
      eor_ff  <= eor_in;
      eom_ff  <= eom_in;
      rsp_ff  <= rsp_in;
   end

   a_j_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (j_ff <= 4'd8))
      else $error("step index out of range");

   a_eom_eor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.end_of_message) |-> rsp_ff.end_of_run)
      else $error("end of message without end of run");

   a_status_nodata: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.has_data) |-> (rsp_ff.out_byte == 8'h00))
      else $error("status result carries a byte");

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      slot_take |=> (!active_ff || (j_ff == 4'd0)))
      else $error("block loaded mid-sequence");

endmodule

FILE: hdl/tea_chained_message_cipher.sv
`timescale 1ns / 1ps
// Blocks of 8 bytes are enciphered by the TEA engine (one round a cycle, 16 rounds,
// plus load and hand-off states); it takes a new block only after handing off the last.
// Result bytes drain from the emitter while the engine runs the next block.
// Reset is synchronous, active high: control state clears, key words to zero,
// out_capacity to 65535 and fill_byte to 0xAD; no clearing pass is needed.
module tea_chained_message_cipher (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  tcmc_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output tcmc_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_wr_en,
   input  logic [tcmc_pkg::CSR_AW-1:0]         csr_index,
   input  logic [31:0]                         csr_wdata
);

   logic [31:0] key0_ff, key1_ff, key2_ff, key3_ff;
   logic [15:0] cap_ff;
   logic [7:0]  fill_ff;

   logic              push_valid, push_ready, pop_valid, pop;
   tcmc_pkg::job_type push_job, pop_job, slot;
   logic              slot_valid, slot_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff <= '0;
         key1_ff <= '0;
         key2_ff <= '0;
         key3_ff <= '0;
         cap_ff  <= tcmc_pkg::CAP_RESET;
         fill_ff <= tcmc_pkg::FILL_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            tcmc_pkg::CSR_KEY0: key0_ff <= csr_wdata;
            tcmc_pkg::CSR_KEY1: key1_ff <= csr_wdata;
            tcmc_pkg::CSR_KEY2: key2_ff <= csr_wdata;
            tcmc_pkg::CSR_KEY3: key3_ff <= csr_wdata;
            tcmc_pkg::CSR_CAP:  cap_ff  <= csr_wdata[15:0];
            tcmc_pkg::CSR_FILL: fill_ff <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   tcmc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .fill_byte   (fill_ff),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_job    (push_job)
   );

   tcmc_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_job    (pop_job)
   );

   tcmc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (pop_valid),
      .job_pop    (pop),
      .job_in     (pop_job),
      .key0       (key0_ff),
      .key1       (key1_ff),
      .key2       (key2_ff),
      .key3       (key3_ff),
      .slot_valid (slot_valid),
      .slot       (slot),
      .slot_take  (slot_take)
   );

   tcmc_emitter u_emitter (
      .clock        (clock),
      .reset        (reset),
      .slot_valid   (slot_valid),
      .slot         (slot),
      .slot_take    (slot_take),
      .out_capacity (cap_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

endmodule
